### hdl/pfde_pkg.sv
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared types, sizes, opcodes and the glyph font for the page frame buffer
// draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pfde_pkg;

  // Store geometry: vertical 8-pixel pages, top row in bit 0.
  localparam int BufferWidth   = 256;
  localparam int DisplayHeight = 32;
  localparam int PageCount     = (DisplayHeight + 7) / 8;
  localparam int StoreBytes    = BufferWidth * PageCount;
  localparam int AddrW         = $clog2(StoreBytes);

  localparam logic [9:0] XMax = 10'(BufferWidth - 1);
  localparam logic [5:0] YMax = 6'(DisplayHeight - 1);

  localparam int GlyphCols = 3;
  localparam int GlyphRows = 5;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_PIXEL = 3'd1,
    OP_VLINE = 3'd2,
    OP_HLINE = 3'd3,
    OP_GLYPH = 3'd4,
    OP_READ  = 3'd5
  } pfde_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_RDATA,
    ST_DONE
  } pfde_state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [9:0] x_pos;
    logic [5:0] y_pos;
    logic [9:0] x_end;
    logic [5:0] y_end;
    logic [7:0] glyph_code;
  } pfde_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       is_read_reply;
  } pfde_res_t;

  // Result of the plot unit for one pixel coordinate.
  typedef struct packed {
    logic             in_bounds;
    logic [AddrW-1:0] addr;
    logic [7:0]       mask;
  } pfde_plot_t;

  // One glyph column, bit r set for row r below the glyph top.
  function automatic logic [4:0] glyph_column(input logic [7:0] code,
                                              input logic [1:0] col);
    logic [7:0] digit;
    logic [4:0] bits;
    digit = code - CharZero;
    bits  = 5'h00;
    if (code == CharMinus) begin
      bits = 5'h04;
    end else if (code == CharDot) begin
      bits = (col == 2'd0) ? 5'h10 : 5'h00;
    end else if (code >= CharZero && code <= CharNine) begin
      case ({digit[3:0], col})
        {4'd0, 2'd0}: bits = 5'h1F;
        {4'd0, 2'd1}: bits = 5'h11;
        {4'd0, 2'd2}: bits = 5'h1F;
        {4'd1, 2'd0}: bits = 5'h00;
        {4'd1, 2'd1}: bits = 5'h1F;
        {4'd1, 2'd2}: bits = 5'h00;
        {4'd2, 2'd0}: bits = 5'h1D;
        {4'd2, 2'd1}: bits = 5'h15;
        {4'd2, 2'd2}: bits = 5'h17;
        {4'd3, 2'd0}: bits = 5'h15;
        {4'd3, 2'd1}: bits = 5'h15;
        {4'd3, 2'd2}: bits = 5'h1F;
        {4'd4, 2'd0}: bits = 5'h07;
        {4'd4, 2'd1}: bits = 5'h04;
        {4'd4, 2'd2}: bits = 5'h1F;
        {4'd5, 2'd0}: bits = 5'h17;
        {4'd5, 2'd1}: bits = 5'h15;
        {4'd5, 2'd2}: bits = 5'h1D;
        {4'd6, 2'd0}: bits = 5'h1F;
        {4'd6, 2'd1}: bits = 5'h15;
        {4'd6, 2'd2}: bits = 5'h1D;
        {4'd7, 2'd0}: bits = 5'h01;
        {4'd7, 2'd1}: bits = 5'h01;
        {4'd7, 2'd2}: bits = 5'h1F;
        {4'd8, 2'd0}: bits = 5'h1F;
        {4'd8, 2'd1}: bits = 5'h15;
        {4'd8, 2'd2}: bits = 5'h1F;
        {4'd9, 2'd0}: bits = 5'h17;
        {4'd9, 2'd1}: bits = 5'h15;
        {4'd9, 2'd2}: bits = 5'h1F;
        default:      bits = 5'h00;
      endcase
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

### hdl/pfde_ram.sv
// ----------------------------------------------------------------------------
// pfde_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/pfde_plot.sv
// ----------------------------------------------------------------------------
// pfde_plot
// Shared plot unit: bounds check, byte address and bit mask for one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_plot (
  input  wire logic [10:0]               px_i,
  input  wire logic [6:0]                py_i,
  output pfde_pkg::pfde_plot_t           plot_o
);
  import pfde_pkg::*;

  logic [31:0] addr_full;

  // Byte index is page * width + column; the page is the row over eight.
  assign addr_full = 32'(py_i[6:3]) * 32'(BufferWidth) + 32'(px_i);

  always_comb begin
    plot_o.in_bounds = (px_i < 11'(BufferWidth)) && (py_i < 7'(DisplayHeight));
    plot_o.addr      = addr_full[AddrW-1:0];
    plot_o.mask      = 8'h01 << py_i[2:0];
  end

endmodule

`default_nettype wire

### hdl/page_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Monochrome page frame store with a sequenced pixel drawing engine.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the in channel (in_valid_i / in_stall_o / in_data_i) and
// every command produces exactly one result transfer on the out channel
// (out_valid_o / out_stall_i / out_data_o). Only a read command returns store
// data; all others return zero with is_read_reply low.
// Every drawn pixel goes through one shared plot unit as a read-modify-write of
// its store byte (ST_RD, then ST_WR), so the single RAM port pair sets the
// drawing rate. The result enters the output register from ST_DONE once that
// register is free, and the next command can be taken in the cycle in which
// that result first shows valid.
// After reset, and on a clear command, the engine sweeps the store to zero,
// one byte per cycle, and stalls the input meanwhile.
// The result sits in an output register, so a new command is taken while a
// result still waits; a command that finishes while the receiver stalls a
// full output register waits until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_draw_engine (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire pfde_pkg::pfde_cmd_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pfde_pkg::pfde_res_t       out_data_o
);
  import pfde_pkg::*;

  pfde_state_e      state_q, state_d;
  pfde_op_e         op_q, op_d;
  logic [10:0]      xb_q, xb_d;
  logic [6:0]       yb_q, yb_d;
  logic [9:0]       cnt_q, cnt_d;
  logic [9:0]       end_q, end_d;
  logic [1:0]       col_q, col_d;
  logic [2:0]       row_q, row_d;
  logic [7:0]       gcode_q, gcode_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             clr_cmd_q, clr_cmd_d;
  pfde_res_t        res_q, res_d;
  logic             out_valid_q, out_valid_d;
  pfde_res_t        out_q, out_d;

  logic [10:0]      px;
  logic [6:0]       py;
  logic [4:0]       gbits;
  logic             pen;
  logic             last;
  pfde_plot_t       plot;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  logic             in_acc;
  logic             out_load;
  logic [5:0]       ylo, yhi, yhi_cl;
  logic [9:0]       xlo, xhi, xhi_cl, x_cl;
  logic             rd_hit;
  logic [31:0]      rd_addr_full;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Current pixel of the command being drawn.
  always_comb begin
    px    = xb_q;
    py    = yb_q;
    gbits = glyph_column(gcode_q, col_q);
    pen   = 1'b0;
    last  = 1'b1;
    case (op_q)
      OP_PIXEL: begin
        pen  = 1'b1;
      end
      OP_VLINE: begin
        py   = 7'(cnt_q[5:0]);
        pen  = 1'b1;
        last = (cnt_q == end_q);
      end
      OP_HLINE: begin
        px   = 11'(cnt_q);
        pen  = 1'b1;
        last = (cnt_q == end_q);
      end
      OP_GLYPH: begin
        px   = xb_q + 11'(col_q);
        py   = yb_q + 7'(row_q);
        pen  = gbits[row_q];
        last = (col_q == 2'(GlyphCols - 1)) && (row_q == 3'(GlyphRows - 1));
      end
      default: begin
        pen  = 1'b0;
      end
    endcase
  end

  pfde_plot u_plot (
    .px_i   (px),
    .py_i   (py),
    .plot_o (plot)
  );

  // Command setup: ordered and clamped line ends, read address.
  always_comb begin
    ylo    = (in_data_i.y_pos > in_data_i.y_end) ? in_data_i.y_end : in_data_i.y_pos;
    yhi    = (in_data_i.y_pos > in_data_i.y_end) ? in_data_i.y_pos : in_data_i.y_end;
    yhi_cl = (yhi > YMax) ? YMax : yhi;
    xlo    = (in_data_i.x_pos > in_data_i.x_end) ? in_data_i.x_end : in_data_i.x_pos;
    xhi    = (in_data_i.x_pos > in_data_i.x_end) ? in_data_i.x_pos : in_data_i.x_end;
    xhi_cl = (xhi > XMax) ? XMax : xhi;
    x_cl   = (in_data_i.x_pos > XMax) ? XMax : in_data_i.x_pos;
    rd_hit = (7'(in_data_i.y_pos) < 7'(PageCount)) &&
             (11'(in_data_i.x_pos) < 11'(BufferWidth));
  end

  assign rd_addr_full = 32'(in_data_i.y_pos) * 32'(BufferWidth) + 32'(in_data_i.x_pos);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    xb_d        = xb_q;
    yb_d        = yb_q;
    cnt_d       = cnt_q;
    end_d       = end_q;
    col_d       = col_q;
    row_d       = row_q;
    gcode_d     = gcode_q;
    clr_addr_d  = clr_addr_q;
    clr_cmd_d   = clr_cmd_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = plot.addr;
    ram_wdata   = ram_rdata | plot.mask;
    ram_raddr   = (state_q == ST_IDLE) ? rd_addr_full[AddrW-1:0] : plot.addr;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = 8'h00;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(StoreBytes - 1)) begin
          state_d = clr_cmd_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = pfde_op_e'(in_data_i.opcode);
          xb_d    = 11'(in_data_i.x_pos);
          yb_d    = 7'(in_data_i.y_pos);
          gcode_d = in_data_i.glyph_code;
          col_d   = 2'd0;
          row_d   = 3'd0;
          res_d   = '0;
          state_d = ST_DONE;
          unique case (pfde_op_e'(in_data_i.opcode))
            OP_CLEAR: begin
              clr_addr_d = '0;
              clr_cmd_d  = 1'b1;
              state_d    = ST_CLEAR;
            end
            OP_PIXEL: begin
              state_d = ST_RD;
            end
            OP_VLINE: begin
              xb_d  = 11'(x_cl);
              cnt_d = 10'(ylo);
              end_d = 10'(yhi_cl);
              if (ylo <= yhi_cl) begin
                state_d = ST_RD;
              end
            end
            OP_HLINE: begin
              cnt_d = xlo;
              end_d = xhi_cl;
              if ((7'(in_data_i.y_pos) < 7'(DisplayHeight)) && (xlo <= xhi_cl)) begin
                state_d = ST_RD;
              end
            end
            OP_GLYPH: begin
              state_d = ST_RD;
            end
            OP_READ: begin
              res_d.is_read_reply = 1'b1;
              if (rd_hit) begin
                state_d = ST_RDATA;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_RD: begin
        if (pen && plot.in_bounds) begin
          state_d = ST_WR;
        end else if (last) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 10'd1;
          row_d = (row_q == 3'(GlyphRows - 1)) ? 3'd0 : row_q + 3'd1;
          col_d = (row_q == 3'(GlyphRows - 1)) ? col_q + 2'd1 : col_q;
        end
      end
      ST_WR: begin
        ram_we = 1'b1;
        if (last) begin
          state_d = ST_DONE;
        end else begin
          cnt_d   = cnt_q + 10'd1;
          row_d   = (row_q == 3'(GlyphRows - 1)) ? 3'd0 : row_q + 3'd1;
          col_d   = (row_q == 3'(GlyphRows - 1)) ? col_q + 2'd1 : col_q;
          state_d = ST_RD;
        end
      end
      ST_RDATA: begin
        res_d.read_data = ram_rdata;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        clr_cmd_d = 1'b0;
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  pfde_ram #(
    .Width (8),
    .Depth (StoreBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      op_q        <= OP_CLEAR;
      clr_addr_q  <= '0;
      clr_cmd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      clr_addr_q  <= clr_addr_d;
      clr_cmd_q   <= clr_cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xb_q    <= xb_d;
    yb_q    <= yb_d;
    cnt_q   <= cnt_d;
    end_q   <= end_d;
    col_q   <= col_d;
    row_q   <= row_d;
    gcode_q <= gcode_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A pixel write only ever targets a byte that passed the bounds check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> plot.in_bounds)
    else $error("pixel write outside the store");

  // No result appears while the power-up clearing pass runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && !clr_cmd_q) |-> !out_valid_q)
    else $error("result during power-up clear");

  // A non-read result never carries store data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.is_read_reply) |-> (out_q.read_data == 8'h00))
    else $error("data on a non-read result");

  // An in-range read transfer fetches its byte in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.opcode == OP_READ && rd_hit) |=> (state_q == ST_RDATA))
    else $error("read did not fetch store byte");

endmodule

`default_nettype wire

### dv/tb_page_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// tb_page_framebuffer_draw_engine
// Self-checking bench for the page frame buffer draw engine. A directed table
// hits the store corners, the clipping rules of pixels, lines and glyphs, the
// out-of-range reads and the spare opcodes. About 900 random commands follow
// across idle and stall phases. A shadow copy of the frame store predicts
// every result that the table does not give, and each result transfer is
// compared with the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_page_framebuffer_draw_engine;
  import pfde_pkg::*;

  localparam logic [2:0] OpSpareSix   = 3'd6;
  localparam logic [2:0] OpSpareSeven = 3'd7;
  localparam logic [7:0] CharLetterA  = 8'h41;

  localparam int unsigned ItemsPerPhase = 225;
  localparam int unsigned HoldOffCycles = 400;
  // A clear walks the whole store, which is the slowest command.
  localparam int unsigned DrainCycles   = 1100;

  typedef struct {
    pfde_cmd_t cmd;
    bit        known;
    pfde_res_t res;
  } stim_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  pfde_cmd_t in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  pfde_res_t out_data_o;

  logic [7:0]  shadow_store [StoreBytes] = '{default: 8'h00};
  pfde_res_t   result_q [$];
  int unsigned error_count   = 0;
  int unsigned checked_count = 0;
  int unsigned op_count [8]  = '{default: 0};
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off_req  = 1'b0;
  logic [9:0]  last_x        = '0;
  logic [5:0]  last_page     = '0;

  page_framebuffer_draw_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin : reset_gen
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    #20ms;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  function automatic void plot_pixel(input int unsigned x, input int unsigned y);
    if (x < BufferWidth && y < DisplayHeight) begin
      shadow_store[(y / 8) * BufferWidth + x] |= 8'(1 << (y % 8));
    end
  endfunction

  // Applies one command to the shadow store and returns its result.
  function automatic pfde_res_t apply_command(input pfde_cmd_t cmd);
    pfde_res_t   res;
    int unsigned lo, hi, tmp, x, i, r;
    logic [14:0] shape;
    res = '0;
    case (cmd.opcode)
      OP_CLEAR: begin
        foreach (shadow_store[k]) shadow_store[k] = 8'h00;
      end
      OP_PIXEL: begin
        plot_pixel(cmd.x_pos, cmd.y_pos);
      end
      OP_VLINE: begin
        x  = (cmd.x_pos >= BufferWidth) ? BufferWidth - 1 : cmd.x_pos;
        lo = cmd.y_pos;
        hi = cmd.y_end;
        if (lo > hi) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        if (hi >= DisplayHeight) hi = DisplayHeight - 1;
        for (i = lo; i <= hi; i++) plot_pixel(x, i);
      end
      OP_HLINE: begin
        if (cmd.y_pos < DisplayHeight) begin
          lo = cmd.x_pos;
          hi = cmd.x_end;
          if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          if (hi >= BufferWidth) hi = BufferWidth - 1;
          for (i = lo; i <= hi; i++) plot_pixel(i, cmd.y_pos);
        end
      end
      OP_GLYPH: begin
        // Three 5-bit columns, column 0 in the low bits, row 0 in bit 0.
        shape = '0;
        if (cmd.glyph_code == CharMinus) begin
          shape = {5'h04, 5'h04, 5'h04};
        end else if (cmd.glyph_code == CharDot) begin
          shape = {5'h00, 5'h00, 5'h10};
        end else if (cmd.glyph_code >= CharZero && cmd.glyph_code <= CharNine) begin
          case (cmd.glyph_code - CharZero)
            8'd0: shape = {5'h1F, 5'h11, 5'h1F};
            8'd1: shape = {5'h00, 5'h1F, 5'h00};
            8'd2: shape = {5'h17, 5'h15, 5'h1D};
            8'd3: shape = {5'h1F, 5'h15, 5'h15};
            8'd4: shape = {5'h1F, 5'h04, 5'h07};
            8'd5: shape = {5'h1D, 5'h15, 5'h17};
            8'd6: shape = {5'h1D, 5'h15, 5'h1F};
            8'd7: shape = {5'h1F, 5'h01, 5'h01};
            8'd8: shape = {5'h1F, 5'h15, 5'h1F};
            default: shape = {5'h1F, 5'h15, 5'h17};
          endcase
        end
        for (i = 0; i < 3; i++) begin
          for (r = 0; r < 5; r++) begin
            if (shape[i * 5 + r]) plot_pixel(cmd.x_pos + i, cmd.y_pos + r);
          end
        end
      end
      OP_READ: begin
        res.is_read_reply = 1'b1;
        if (cmd.y_pos < PageCount && cmd.x_pos < BufferWidth) begin
          res.read_data = shadow_store[cmd.y_pos * BufferWidth + cmd.x_pos];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic stim_row_t stim(input logic [2:0] op, input int x, input int y,
                                     input int xe, input int ye, input int gc,
                                     input bit known, input logic [7:0] data);
    stim_row_t s;
    s.cmd = '{opcode: op, x_pos: 10'(x), y_pos: 6'(y), x_end: 10'(xe),
              y_end: 6'(ye), glyph_code: 8'(gc)};
    s.known             = known;
    s.res.read_data     = data;
    s.res.is_read_reply = (op == OP_READ);
    return s;
  endfunction

  // Mostly on-store drawing with short spans and reads near recent drawing;
  // the rest uses the full field ranges.
  function automatic pfde_cmd_t random_command();
    pfde_cmd_t   c;
    logic [63:0] raw;
    int unsigned pick;
    raw  = {$urandom(), $urandom()};
    c    = raw[$bits(pfde_cmd_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 1)       c.opcode = OP_CLEAR;
    else if (pick < 14) c.opcode = OP_PIXEL;
    else if (pick < 24) c.opcode = OP_VLINE;
    else if (pick < 34) c.opcode = OP_HLINE;
    else if (pick < 54) c.opcode = OP_GLYPH;
    else if (pick < 94) c.opcode = OP_READ;
    else                c.opcode = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 4) != 0) begin
      c.x_pos = 10'($urandom_range(0, BufferWidth - 1));
      c.y_pos = 6'($urandom_range(0, DisplayHeight - 1));
      c.x_end = c.x_pos + 10'($urandom_range(0, 48)) - 10'd24;
      c.y_end = c.y_pos + 6'($urandom_range(0, 12)) - 6'd6;
      if (c.opcode == OP_READ) begin
        if ($urandom_range(0, 1) != 0) begin
          c.x_pos = last_x + 10'($urandom_range(0, 2));
          c.y_pos = last_page;
        end else begin
          c.y_pos = 6'($urandom_range(0, PageCount - 1));
        end
      end else begin
        last_x    = c.x_pos;
        last_page = c.y_pos >> 3;
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, 11);
      if (pick < 10) c.glyph_code = CharZero + 8'(pick);
      else           c.glyph_code = (pick == 10) ? CharMinus : CharDot;
    end
    return c;
  endfunction

  // Offers one command and records its expected result once it transfers.
  task automatic send_command(input pfde_cmd_t cmd, input bit known,
                              input pfde_res_t known_res);
    pfde_res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_command(cmd);
    result_q.push_back(known ? known_res : predicted);
    op_count[cmd.opcode]++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    pfde_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked_count++;
      if (result_q.size() == 0) begin
        report_mismatch("result transfer with no command outstanding");
      end else begin
        want = result_q.pop_front();
        if (out_data_o.read_data !== want.read_data) begin
          report_mismatch($sformatf("read_data got %h want %h",
                                    out_data_o.read_data, want.read_data));
        end
        if (out_data_o.is_read_reply !== want.is_read_reply) begin
          report_mismatch($sformatf("is_read_reply got %b want %b",
                                    out_data_o.is_read_reply, want.is_read_reply));
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t rows [$];
    int unsigned phase, n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Store corners, clipping, out-of-range reads and spare opcodes.
    rows.push_back(stim(OP_READ, 0, 0, 0, 0, 0, 1'b1, 8'h00));
    rows.push_back(stim(OP_PIXEL, 0, 0, 0, 0, 0, 1'b1, 8'h00));
    rows.push_back(stim(OP_READ, 0, 0, 0, 0, 0, 1'b1, 8'h01));
    rows.push_back(stim(OP_PIXEL, 255, 31, 0, 0, 0, 1'b1, 8'h00));
    rows.push_back(stim(OP_READ, 255, 3, 0, 0, 0, 1'b1, 8'h80));
    rows.push_back(stim(OP_PIXEL, 256, 0, 0, 0, 0, 1'b1, 8'h00));
    rows.push_back(stim(OP_PIXEL, 1023, 63, 1023, 63, 255, 1'b1, 8'h00));
    rows.push_back(stim(OP_READ, 256, 0, 0, 0, 0, 1'b1, 8'h00));
    rows.push_back(stim(OP_READ, 0, 4, 0, 0, 0, 1'b1, 8'h00));
    rows.push_back(stim(OP_READ, 1023, 63, 0, 0, 0, 1'b1, 8'h00));
    // Reversed ends with the column and the end row clamped.
    rows.push_back(stim(OP_VLINE, 1023, 40, 0, 3, 0, 1'b0, 8'h00));
    rows.push_back(stim(OP_READ, 255, 0, 0, 0, 0, 1'b0, 8'h00));
    // The start row lies past the clamped end, so nothing is drawn.
    rows.push_back(stim(OP_VLINE, 7, 50, 0, 40, 0, 1'b0, 8'h00));
    rows.push_back(stim(OP_HLINE, 300, 9, 5, 0, 0, 1'b0, 8'h00));
    rows.push_back(stim(OP_READ, 100, 1, 0, 0, 0, 1'b0, 8'h00));
    rows.push_back(stim(OP_HLINE, 10, 32, 20, 0, 0, 1'b0, 8'h00));
    rows.push_back(stim(OP_GLYPH, 20, 0, 0, 0, CharZero + 8, 1'b0, 8'h00));
    rows.push_back(stim(OP_READ, 21, 0, 0, 0, 0, 1'b0, 8'h00));
    rows.push_back(stim(OP_GLYPH, 40, 2, 0, 0, CharMinus, 1'b0, 8'h00));
    rows.push_back(stim(OP_GLYPH, 41, 2, 0, 0, CharDot, 1'b0, 8'h00));
    rows.push_back(stim(OP_READ, 41, 0, 0, 0, 0, 1'b0, 8'h00));
    // A glyph at the bottom right corner is only partly drawn.
    rows.push_back(stim(OP_GLYPH, 254, 29, 0, 0, CharZero, 1'b0, 8'h00));
    rows.push_back(stim(OP_READ, 255, 3, 0, 0, 0, 1'b0, 8'h00));
    rows.push_back(stim(OP_GLYPH, 60, 0, 0, 0, CharLetterA, 1'b0, 8'h00));
    rows.push_back(stim(OpSpareSix, 5, 5, 5, 5, 5, 1'b1, 8'h00));
    rows.push_back(stim(OpSpareSeven, 5, 5, 5, 5, 5, 1'b1, 8'h00));
    rows.push_back(stim(OP_CLEAR, 0, 0, 0, 0, 0, 1'b1, 8'h00));
    rows.push_back(stim(OP_READ, 255, 0, 0, 0, 0, 1'b1, 8'h00));
    foreach (rows[i]) send_command(rows[i].cmd, rows[i].known, rows[i].res);

    for (phase = 0; phase < 4; phase++) begin
      // The sender pauses until every outstanding result has come back.
      wait_results_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (n = 0; n < ItemsPerPhase; n++) begin
        // A long output hold-off while commands keep coming backs up the
        // output register and then the input.
        if (phase == 0 && n == 60) hold_off_req = 1'b1;
        send_command(random_command(), 1'b0, '0);
      end
    end

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("summary: %0d reads, %0d glyphs, %0d lines, %0d pixels, %0d clears, %0d spare",
             op_count[OP_READ], op_count[OP_GLYPH],
             op_count[OP_VLINE] + op_count[OP_HLINE], op_count[OP_PIXEL],
             op_count[OP_CLEAR], op_count[OpSpareSix] + op_count[OpSpareSeven]);
    $display("summary: %0d results checked over four idle/stall phases, %0d mismatches",
             checked_count, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
hdl/pfde_pkg.sv
hdl/pfde_ram.sv
hdl/pfde_plot.sv
hdl/page_framebuffer_draw_engine.sv
dv/tb_page_framebuffer_draw_engine.sv
